// ===== rtl/cni_pkg.sv =====
// shared types, codes and widths for the composite newton-cotes integrator
package cni_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 13;
    localparam int SUM_W     = 48;
    localparam int DX_W      = 33;
    localparam int MS_W      = 47;
    localparam int MD_W      = 34;
    localparam int DIV_W     = 16;
    localparam int REM_W     = DIV_W + 1;
    localparam int DVD_W     = MS_W + MD_W - 16;
    localparam int ACC_W     = REM_W + DVD_W;
    localparam int MUL_STEPS = MD_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = 7;

    typedef logic [1:0] t_rule;
    localparam t_rule RULE_TRAP = 2'd0;
    localparam t_rule RULE_S13  = 2'd1;
    localparam t_rule RULE_S38  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BADCOUNT = 2'd1;
    localparam t_status ST_TOOMANY  = 2'd2;
    localparam t_status ST_SAT      = 2'd3;

    typedef enum logic [2:0] {
        S_ACC,
        S_PREP,
        S_MUL,
        S_ALIGN,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul_step;
        logic align;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/cni_ctrl.sv =====
// sequencer: accumulation, then shift-add multiply and restoring divide per set; a rejected set skips to the output
module cni_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    input  cni_pkg::t_sts i_sts,
    output cni_pkg::t_cmd o_cmd
);
    import cni_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               accept;

    assign accept = i_s_tvalid && (r_state == S_ACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = '0;
        case (r_state)
            S_ACC: begin
                if (accept && i_s_tlast) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = i_sts.skip ? S_OUT : S_MUL;
            end
            S_MUL: begin
                if (r_count == CNT_W'(MUL_STEPS - 1)) n_state = S_ALIGN;
                else n_count = r_count + 1'b1;
            end
            S_ALIGN: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_count == CNT_W'(DIV_STEPS - 1)) n_state = S_OUT;
                else n_count = r_count + 1'b1;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_ACC;
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_ACC: begin
                o_s_tready   = 1'b1;
                o_cmd.load   = i_s_tvalid;
            end
            S_PREP:  o_cmd.prep     = 1'b1;
            S_MUL:   o_cmd.mul_step = 1'b1;
            S_ALIGN: o_cmd.align    = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_OUT:   o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/cni_dp.sv =====
// datapath: weighted accumulation, serial multiply, serial divide, output register
module cni_dp #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata,
    input  logic [63:0]           i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tready,
    input  cni_pkg::t_cmd         i_cmd,
    output cni_pkg::t_sts         o_sts,
    output logic                  o_m_tvalid,
    output logic [31:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser
);
    import cni_pkg::*;

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SAMPLES);

    t_rule                    r_rule;
    logic [IDX_W-1:0]         r_index;
    logic [1:0]               r_mod3;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DATA_W-1:0] r_first;

    logic signed [SUM_W-1:0]  r_fsum;
    logic signed [DX_W-1:0]   r_dx;
    logic [IDX_W-1:0]         r_m;
    t_status                  r_stat;
    logic [MS_W-1:0]          r_ms;
    logic [DIV_W-1:0]         r_div;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_acc, n_acc;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_data, n_out_data;
    t_status                  r_out_user, n_out_user;

    logic signed [DATA_W-1:0] x_in, y_in, first_eff;
    logic signed [34:0]       y_ext, wy;
    logic [2:0]               weight;
    logic                     in_range, fits;
    logic signed [SUM_W-1:0]  sum_upd;
    logic signed [DX_W-1:0]   dx;
    t_status                  stat_new;
    logic [1:0]               mod3_inc;

    logic [SUM_W-1:0]         sum_neg;
    logic [DX_W-1:0]          dx_neg, abs_dx;
    logic [MS_W-1:0]          abs_sum;
    logic [MD_W-1:0]          md;
    logic [DIV_W-1:0]         den_m;

    logic [SUM_W-1:0]         mul_hi;
    logic [REM_W-1:0]         rem_sh, rem_new;
    logic                     q_bit;

    logic [DVD_W-1:0]         quo;
    logic                     over;

    assign x_in     = signed'(i_s_tdata[31:0]);
    assign y_in     = signed'(i_s_tdata[63:32]);
    assign in_range = r_index < MAX_IDX;
    assign y_ext    = {{3{y_in[31]}}, y_in};
    assign mod3_inc = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;

    // sample weight: ends weigh one, interior by rule
    always_comb begin
        if (r_index == '0 || i_s_tlast) begin
            weight = 3'd1;
        end else begin
            case (r_rule)
                RULE_TRAP: weight = 3'd2;
                RULE_S13:  weight = r_index[0] ? 3'd4 : 3'd2;
                RULE_S38:  weight = (r_mod3 == 2'd0) ? 3'd2 : 3'd3;
                default:   weight = 3'd0;
            endcase
        end
    end

    always_comb begin
        case (weight)
            3'd1:    wy = y_ext;
            3'd2:    wy = y_ext <<< 1;
            3'd3:    wy = y_ext + (y_ext <<< 1);
            3'd4:    wy = y_ext <<< 2;
            default: wy = '0;
        endcase
    end

    assign sum_upd   = r_sum + {{(SUM_W - 35){wy[34]}}, wy};
    assign first_eff = (r_index == '0) ? x_in : r_first;
    assign dx        = {x_in[31], x_in} - {first_eff[31], first_eff};

    always_comb begin
        if (r_index == '0) begin
            fits = 1'b0;
        end else begin
            case (r_rule)
                RULE_TRAP: fits = 1'b1;
                RULE_S13:  fits = ~r_index[0];
                RULE_S38:  fits = (r_mod3 == 2'd0);
                default:   fits = 1'b0;
            endcase
        end
    end

    always_comb begin
        if (!in_range)  stat_new = ST_TOOMANY;
        else if (!fits) stat_new = ST_BADCOUNT;
        else            stat_new = ST_OK;
    end

    // magnitudes and divisor for the closing arithmetic
    assign sum_neg = -r_fsum;
    assign abs_sum = r_fsum[SUM_W-1] ? sum_neg[MS_W-1:0] : r_fsum[MS_W-1:0];
    assign dx_neg  = -r_dx;
    assign abs_dx  = r_dx[DX_W-1] ? dx_neg : r_dx;
    assign md      = (r_rule == RULE_S38) ? ({1'b0, abs_dx} + {abs_dx, 1'b0})
                                          : {1'b0, abs_dx};

    always_comb begin
        case (r_rule)
            RULE_TRAP: den_m = {2'b00, r_m, 1'b0};
            RULE_S13:  den_m = {3'b000, r_m} + {2'b00, r_m, 1'b0};
            default:   den_m = {r_m, 3'b000};
        endcase
    end

    // shift-add multiply on the high half, restoring divide on the remainder
    assign mul_hi  = r_acc[ACC_W-1:MD_W]
                   + (r_acc[0] ? {1'b0, r_ms} : {SUM_W{1'b0}});
    assign rem_sh  = {r_acc[ACC_W-2:DVD_W], r_acc[DVD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_div};
    assign rem_new = q_bit ? rem_sh - {1'b0, r_div} : rem_sh;

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.prep) begin
            n_acc = {{(ACC_W - MD_W){1'b0}}, md};
        end else if (i_cmd.mul_step) begin
            n_acc = {1'b0, mul_hi, r_acc[MD_W-1:1]};
        end else if (i_cmd.align) begin
            n_acc = {{REM_W{1'b0}}, r_acc[ACC_W-2:16]};
        end else if (i_cmd.div_step) begin
            n_acc = {rem_new, r_acc[DVD_W-2:0], q_bit};
        end
    end

    // saturation and sign of the quotient
    assign quo  = r_acc[DVD_W-1:0];
    assign over = (|quo[DVD_W-1:32])
               || (quo[31:0] > (r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF));

    always_comb begin
        if (r_stat != ST_OK) begin
            n_out_data = '0;
            n_out_user = r_stat;
        end else if (over) begin
            n_out_data = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            n_out_user = ST_SAT;
        end else begin
            n_out_data = r_neg ? 32'd0 - quo[31:0] : quo[31:0];
            n_out_user = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule      <= RULE_TRAP;
            r_index     <= '0;
            r_mod3      <= '0;
            r_sum       <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_rule <= i_cfg_wdata;
            if (i_cmd.load) begin
                if (i_s_tlast) begin
                    r_index <= '0;
                    r_mod3  <= '0;
                    r_sum   <= '0;
                    r_first <= '0;
                end else if (in_range) begin
                    r_sum   <= sum_upd;
                    r_first <= first_eff;
                    r_index <= r_index + 1'b1;
                    r_mod3  <= mod3_inc;
                end
            end
            if (i_cmd.out_load)             r_out_valid <= 1'b1;
            else if (i_m_tready)            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_s_tlast) begin
            r_fsum <= in_range ? sum_upd : r_sum;
            r_dx   <= dx;
            r_m    <= r_index;
            r_stat <= stat_new;
        end
        if (i_cmd.prep) begin
            r_ms  <= abs_sum;
            r_div <= den_m;
            r_neg <= r_fsum[SUM_W-1] ^ r_dx[DX_W-1];
        end
        r_acc <= n_acc;
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_sts.skip     = (r_stat != ST_OK);
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;
    assign o_m_tuser      = r_out_user;

endmodule

// ===== rtl/composite_newton_cotes_integrator.sv =====
// samples are taken one per cycle while the block accumulates; the closing sample's result is
// computed after its request is accepted (prepare, 34-step shift-add multiply, align, 65-step
// restoring divide, output load), a rejected set going from prepare straight to output load;
// input stalls during the closing arithmetic and, at its end, while an earlier unaccepted
// result still holds the output register
// reset: synchronous active-low i_rst_n clears rule, index, sum, first x and output valid
module composite_newton_cotes_integrator #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] x_value, [63:32] y_value
    input  logic        i_s_axis_tlast,   // last_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] integral
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import cni_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cni_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cni_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tlast   (i_s_axis_tlast),
        .i_m_tready  (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule

// ===== rtl/cni_checker.sv =====
// port-level checks for the integrator, bound to the top level
module cni_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import cni_pkg::*;

    // closing request always leaves accumulation, so input stalls next cycle
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input not stalled after closing sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_BADCOUNT || o_m_axis_tuser == ST_TOOMANY)
            |-> o_m_axis_tdata == 32'd0)
        else $error("rejected set with nonzero integral");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_SAT
            |-> o_m_axis_tdata == 32'h7FFF_FFFF || o_m_axis_tdata == 32'h8000_0000)
        else $error("saturated result not at a bound");

endmodule

bind composite_newton_cotes_integrator cni_checker u_cni_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the composite newton-cotes integrator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cni_pkg::*;

    localparam int          MAX_SAMPLES    = 4096;
    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 4;
    localparam int          RANDOM_SAMPLES = 1900;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          END_CYCLES     = 120;
    localparam t_rule       RULE_UNUSED    = 2'd3;

    typedef struct packed {
        logic [31:0] integral;
        t_status     status;
    } integral_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = RULE_TRAP;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // predictor state, mirrors the block
    t_rule       rule_q;
    int unsigned sample_idx;
    longint      weighted_sum;
    longint      first_x;

    integral_result_t expected_integrals[$];
    int unsigned      mismatch_count = 0;
    int unsigned      samples_sent   = 0;
    bit               no_gaps        = 1'b0;
    int unsigned      stall_left     = 0;

    composite_newton_cotes_integrator #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // folds one accepted sample into the running sum, closes the set on the last one
    function automatic void integrate_sample(logic [31:0] x, logic [31:0] y, logic last);
        longint           wgt, num, den, dx, abs_sum, abs_dx;
        bit               fits, neg;
        logic [127:0]     prod, quo, lim;
        integral_result_t res;
        if (sample_idx < MAX_SAMPLES) begin
            if (sample_idx == 0)
                first_x = longint'($signed(x));
            if (sample_idx == 0 || last)
                wgt = 1;
            else begin
                case (rule_q)
                    RULE_TRAP: wgt = 2;
                    RULE_S13:  wgt = sample_idx[0] ? 4 : 2;
                    RULE_S38:  wgt = (sample_idx % 3 == 0) ? 2 : 3;
                    default:   wgt = 0;
                endcase
            end
            weighted_sum += wgt * longint'($signed(y));
            if (!last)
                sample_idx++;
        end
        if (!last)
            return;

        case (rule_q)
            RULE_TRAP: fits = (sample_idx != 0);
            RULE_S13:  fits = (sample_idx != 0) && !sample_idx[0];
            RULE_S38:  fits = (sample_idx != 0) && (sample_idx % 3 == 0);
            default:   fits = 1'b0;
        endcase
        res.integral = '0;
        res.status   = ST_OK;
        if (sample_idx >= MAX_SAMPLES)
            res.status = ST_TOOMANY;
        else if (!fits)
            res.status = ST_BADCOUNT;
        else begin
            dx      = longint'($signed(x)) - first_x;
            num     = (rule_q == RULE_S38) ? 3 : 1;
            den     = (rule_q == RULE_TRAP) ? 2 : (rule_q == RULE_S13) ? 3 : 8;
            neg     = (weighted_sum < 0) != (dx < 0);
            abs_sum = (weighted_sum < 0) ? -weighted_sum : weighted_sum;
            abs_dx  = ((dx < 0) ? -dx : dx) * num;
            prod    = 128'(abs_sum) * 128'(abs_dx);
            quo     = prod / (128'(den) * 128'(sample_idx) * 128'(65536));
            lim     = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (quo > lim) begin
                res.status   = ST_SAT;
                res.integral = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                res.integral = neg ? -quo[31:0] : quo[31:0];
            end
        end
        expected_integrals.push_back(res);
        sample_idx   = 0;
        weighted_sum = 0;
        first_x      = 0;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            rule_q       = RULE_TRAP;
            sample_idx   = 0;
            weighted_sum = 0;
            first_x      = 0;
        end else begin
            if (cfg_we)
                rule_q = cfg_wdata;
            if (s_tvalid && s_tready)
                integrate_sample(s_tdata[31:0], s_tdata[63:32], s_tlast);
        end
    end

    always @(posedge clk) begin : check_results
        integral_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_integrals.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got integral %h status %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_integrals.pop_front();
                if (m_tdata !== want.integral) begin
                    mismatch_count++;
                    $display("%0t: integral mismatch, expected %h, got %h",
                             $time, want.integral, m_tdata);
                end
                if (m_tuser !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_tuser);
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        if (stall_left != 0)
            stall_left--;
        else if (m_tready && !no_gaps) begin
            m_tready   <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_tready   <= 1'b1;
            stall_left = $urandom_range(1, 8);
        end
    end

    // entered and left at a falling edge
    task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        samples_sent++;
        @(negedge clk);
    endtask

    // hold off requests until every outstanding result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_integrals.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_rule(input t_rule r);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_single_sample();
        // rule left at its reset value
        send_sample(32'h1234_5678, 32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_field_extremes();
        set_rule(RULE_TRAP);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // reversed abscissae, negative clamp
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0000_8000, 32'h0000_8000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_simpson_third();
        set_rule(RULE_S13);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0000_8000, 32'h0000_4000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
        // odd interval count
        send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0000_8000, 32'h0002_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
        send_sample(32'h0001_8000, 32'h0004_0000, 1'b1);
    endtask

    task automatic test_simpson_three_eighths();
        set_rule(RULE_S38);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0000_8000, 32'h0000_8000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0001_8000, 32'h0001_8000, 1'b1);
        // two intervals, not a multiple of three
        send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0000_8000, 32'h0001_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_unused_rule();
        set_rule(RULE_UNUSED);
        send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_random_sets();
        int unsigned start, r, k, m, nsets, ymode;
        logic [31:0] x0, step, xv, yv;
        bit          ragged_x;
        t_rule       rule_sel;
        start = samples_sent;
        while (samples_sent - start < RANDOM_SAMPLES) begin
            r = $urandom_range(0, 9);
            rule_sel = (r < 3) ? RULE_TRAP : (r < 6) ? RULE_S13 : (r < 9) ? RULE_S38 : RULE_UNUSED;
            set_rule(rule_sel);
            no_gaps = ($urandom_range(0, 3) == 0);
            nsets   = $urandom_range(3, 12);
            repeat (nsets) begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                // mostly counts the rule accepts, the rest arbitrary
                if ($urandom_range(0, 9) < 8)
                    m = (rule_sel == RULE_S13) ? 2 * k : (rule_sel == RULE_S38) ? 3 * k : k;
                else
                    m = $urandom_range(0, 20);
                x0       = $urandom;
                step     = $urandom_range(0, 32'h4_0000);
                if ($urandom_range(0, 1))
                    step = -step;
                ragged_x = ($urandom_range(0, 9) == 0);
                ymode    = $urandom_range(0, 2);
                for (int i = 0; i <= m; i++) begin
                    xv = ragged_x ? $urandom : x0 + i * step;
                    case (ymode)
                        0:       yv = $urandom;
                        1:       yv = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
                        default: yv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    endcase
                    send_sample(xv, yv, i == m);
                end
                if ($urandom_range(0, 7) == 0)
                    wait_idle();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_single_sample();
        test_field_extremes();
        test_simpson_third();
        test_simpson_three_eighths();
        test_unused_rule();
        test_random_sets();
        wait_idle();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
